@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// DCMF_ASSERT checks a property at the rising clock edge while reset is released.
// DCMF_ASSERT_ALWAYS checks a property at every rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DCMF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: check failed");
`define DCMF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define DCMF_ASSERT(label, clk, rstn, prop)
`define DCMF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/dcmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dcmf_pkg: shared constants and types of the dark channel minimum filter.
// Frame limits, derived widths, register indexes and the geometry bundle.
// ----------------------------------------------------------------------------
package dcmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_PATCH  = 16;

    localparam int PIX_BITS = 8;
    localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int P_BITS    = $clog2(MAX_PATCH + 1);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int LINE_BITS = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;

    localparam int AW          = $clog2(MAX_PATCH * MAX_WIDTH);
    localparam int STORE_DEPTH = 2 ** AW;
    localparam int N_BITS      = $clog2(MAX_WIDTH * MAX_HEIGHT + STORE_DEPTH);
    localparam int DIV_BITS    = $clog2(N_BITS);

    // Configuration register fields.
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_PATCH_BITS  = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATCH_SIZE   = 2'd2;

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CFG_PATCH_BITS-1:0]  PATCH_RESET  = 5'd15;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Saturated frame geometry and the products derived from it.
    typedef struct packed {
        logic [W_BITS-1:0] w;
        logic [H_BITS-1:0] h;
        logic [P_BITS-1:0] p;
        logic [N_BITS-1:0] lag;
        logic [N_BITS-1:0] total;
    } geo_t;

endpackage

@@ sv/dcmf_min_unit.sv @@
// ----------------------------------------------------------------------------
// dcmf_min_unit: the shared 8-bit minimum comparator.
// Serves both the column reduction and the window scan of the sequencer.
// ----------------------------------------------------------------------------
module dcmf_min_unit (
    input  logic [dcmf_pkg::PIX_BITS-1:0] a,
    input  logic [dcmf_pkg::PIX_BITS-1:0] b,
    output logic [dcmf_pkg::PIX_BITS-1:0] y
);

    assign y = (a < b) ? a : b;

endmodule

@@ sv/dcmf_line_store.sv @@
// ----------------------------------------------------------------------------
// dcmf_line_store: ring of reduced pixel values covering a patch of rows.
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module dcmf_line_store (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [dcmf_pkg::AW-1:0]       wr_addr,
    input  logic [dcmf_pkg::PIX_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [dcmf_pkg::AW-1:0]       rd_addr,
    output logic [dcmf_pkg::PIX_BITS-1:0] rd_data
);

    logic [dcmf_pkg::PIX_BITS-1:0] mem [dcmf_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/dcmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcmf_ctrl: sequencer of the patch minimum.
// Writes each reduced pixel to the row store, keeps a line of column minima
// for the current window and reduces it with the shared comparator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcmf_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dcmf_pkg::geo_t                geo,
    input  logic                          geo_ready,
    input  logic                          geo_changed,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_op,
    input  logic [dcmf_pkg::PIX_BITS-1:0] s_red,
    input  logic [dcmf_pkg::PIX_BITS-1:0] s_green,
    input  logic [dcmf_pkg::PIX_BITS-1:0] s_blue,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dcmf_pkg::PIX_BITS-1:0] m_dark,
    output logic                          m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_COL_START,
        ST_COL_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam int PB = dcmf_pkg::PIX_BITS;
    localparam int NB = dcmf_pkg::N_BITS;
    localparam int WB = dcmf_pkg::W_BITS;
    localparam int HB = dcmf_pkg::H_BITS;
    localparam int PS = dcmf_pkg::P_BITS;
    localparam int LB = dcmf_pkg::LINE_BITS;
    localparam int AB = dcmf_pkg::AW;
    localparam int DB = dcmf_pkg::DIV_BITS;
    localparam logic [DB-1:0] DIV_LAST = DB'(NB - 1);

    state_t state_reg, state_next;
    logic [NB-1:0]                n_reg, n_next;
    logic [NB-1:0]                pos_reg, pos_next;
    logic [dcmf_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [dcmf_pkg::COL_BITS-1:0] col_reg, col_next;
    logic                         resync_reg, resync_next;
    logic                         line_ok_reg, line_ok_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         pend_reg, pend_next;

    logic [AB-1:0]                base_reg, base_next;
    logic [AB-1:0]                col_addr_reg, col_addr_next;
    logic [PS-1:0]                dc_reg, dc_next;
    logic [PS-1:0]                dr_reg, dr_next;
    logic [PS-1:0]                rows_lim_reg, rows_lim_next;
    logic [PS-1:0]                scan_idx_reg, scan_idx_next;
    logic                         fill_reg, fill_next;
    logic [PB-1:0]                acc_reg, acc_next;
    logic [PB-1:0]                line_reg [dcmf_pkg::MAX_PATCH];
    logic [PB-1:0]                line_next [dcmf_pkg::MAX_PATCH];
    logic [DB-1:0]                div_cnt_reg, div_cnt_next;
    logic [WB-1:0]                rem_reg, rem_next;
    logic [NB-1:0]                quo_reg, quo_next;
    logic [PB-1:0]                out_data_reg, out_data_next;
    logic                         out_last_reg, out_last_next;

    logic          s_accept;
    logic          out_load;
    logic          wr_en;
    logic [PB-1:0] wr_data;
    logic          rd_en;
    logic [PB-1:0] rd_data;
    logic [PB-1:0] min_b;
    logic [PB-1:0] min_y;
    logic [PB-1:0] red_green;
    logic [PB-1:0] pixel_min;
    logic          n_ge_lag;
    logic [NB-1:0] pos_now;
    logic [WB-1:0] trial;
    logic          take;
    logic [HB-1:0] h_minus_r;
    logic [WB:0]   col_sum;
    logic          more_cols;
    logic          issue;
    logic          pos_is_last;

    assign s_tready  = (state_reg == ST_IDLE) && geo_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign red_green = (s_red < s_green) ? s_red : s_green;
    assign pixel_min = (red_green < s_blue) ? red_green : s_blue;
    // Drain ticks and pixels past the frame stand for the padding value.
    assign wr_data   = ((s_op == dcmf_pkg::OP_PIXEL) && (n_reg < geo.total)) ?
                       pixel_min : dcmf_pkg::PIX_MAX;
    assign wr_en     = s_accept;

    assign n_ge_lag  = n_reg >= geo.lag;
    assign pos_now   = n_reg - geo.lag;
    assign pos_is_last = pos_reg == (geo.total - NB'(1));

    assign trial     = {rem_reg[WB-2:0], quo_reg[NB-1]};
    assign take      = trial >= geo.w;
    assign h_minus_r = geo.h - HB'(row_reg);
    assign col_sum   = (WB + 1)'(col_reg) + (WB + 1)'(dc_reg);
    assign more_cols = fill_reg && ((dc_reg + PS'(1)) < geo.p);
    assign issue     = dr_reg < rows_lim_reg;

    assign min_b = (state_reg == ST_SCAN) ? line_reg[scan_idx_reg[LB-1:0]] : rd_data;

    dcmf_min_unit u_min (
        .a (acc_reg),
        .b (min_b),
        .y (min_y)
    );

    dcmf_line_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[AB-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (col_addr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        resync_next    = resync_reg;
        line_ok_next   = line_ok_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        base_next      = base_reg;
        col_addr_next  = col_addr_reg;
        dc_next        = dc_reg;
        dr_next        = dr_reg;
        rows_lim_next  = rows_lim_reg;
        scan_idx_next  = scan_idx_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        line_next      = line_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!n_ge_lag) begin
                        n_next = n_reg + NB'(1);
                    end else if (pos_now >= geo.total) begin
                        n_next      = '0;
                        row_next    = '0;
                        col_next    = '0;
                        resync_next = 1'b0;
                    end else begin
                        pos_next  = pos_now;
                        base_next = n_reg[AB-1:0] - geo.lag[AB-1:0];
                        if (resync_reg) begin
                            rem_next     = '0;
                            quo_next     = pos_now;
                            div_cnt_next = DIV_LAST;
                            state_next   = ST_DIV;
                        end else begin
                            state_next = ST_SETUP;
                        end
                    end
                end
            end
            ST_DIV: begin
                // Restoring division of the position by the width, one bit a cycle.
                rem_next = take ? (trial - geo.w) : trial;
                quo_next = {quo_reg[NB-2:0], take};
                if (div_cnt_reg == '0) begin
                    row_next     = quo_next[dcmf_pkg::ROW_BITS-1:0];
                    col_next     = rem_next[dcmf_pkg::COL_BITS-1:0];
                    resync_next  = 1'b0;
                    line_ok_next = 1'b0;
                    state_next   = ST_SETUP;
                end else begin
                    div_cnt_next = div_cnt_reg - DB'(1);
                end
            end
            ST_SETUP: begin
                rows_lim_next = (h_minus_r < HB'(geo.p)) ? PS'(h_minus_r) : geo.p;
                if ((col_reg == '0) || !line_ok_reg) begin
                    fill_next = 1'b1;
                    dc_next   = '0;
                end else begin
                    // Slide the window one column: only the new right column is read.
                    fill_next = 1'b0;
                    for (int i = 0; i < dcmf_pkg::MAX_PATCH - 1; i++) begin
                        line_next[i] = line_reg[i + 1];
                    end
                    dc_next = geo.p - PS'(1);
                end
                state_next = ST_COL_START;
            end
            ST_COL_START: begin
                if (col_sum >= (WB + 1)'(geo.w)) begin
                    line_next[dc_reg[LB-1:0]] = dcmf_pkg::PIX_MAX;
                    if (more_cols) begin
                        dc_next = dc_reg + PS'(1);
                    end else begin
                        scan_idx_next = '0;
                        acc_next      = dcmf_pkg::PIX_MAX;
                        state_next    = ST_SCAN;
                    end
                end else begin
                    col_addr_next = base_reg + AB'(dc_reg);
                    dr_next       = '0;
                    acc_next      = dcmf_pkg::PIX_MAX;
                    pend_next     = 1'b0;
                    state_next    = ST_COL_READ;
                end
            end
            ST_COL_READ: begin
                // Reads are issued one row apart; each read's data returns in the following cycle.
                if (issue) begin
                    rd_en         = 1'b1;
                    col_addr_next = col_addr_reg + AB'(geo.w);
                    dr_next       = dr_reg + PS'(1);
                end
                pend_next = issue;
                if (pend_reg) begin
                    acc_next = min_y;
                end
                if (!issue && !pend_reg) begin
                    line_next[dc_reg[LB-1:0]] = acc_reg;
                    if (more_cols) begin
                        dc_next    = dc_reg + PS'(1);
                        state_next = ST_COL_START;
                    end else begin
                        scan_idx_next = '0;
                        acc_next      = dcmf_pkg::PIX_MAX;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                acc_next      = min_y;
                scan_idx_next = scan_idx_reg + PS'(1);
                if (scan_idx_reg == (geo.p - PS'(1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    out_last_next  = pos_is_last;
                    line_ok_next   = 1'b1;
                    if (pos_is_last) begin
                        n_next   = '0;
                        row_next = '0;
                        col_next = '0;
                    end else begin
                        n_next = n_reg + NB'(1);
                        if ((WB'(col_reg) + WB'(1)) == geo.w) begin
                            col_next = '0;
                            row_next = row_reg + dcmf_pkg::ROW_BITS'(1);
                        end else begin
                            col_next = col_reg + dcmf_pkg::COL_BITS'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // New geometry invalidates the tracked row, column and window line.
        if (geo_changed) begin
            resync_next  = 1'b1;
            line_ok_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            resync_reg    <= 1'b0;
            line_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            resync_reg    <= resync_next;
            line_ok_reg   <= line_ok_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
        pos_reg      <= pos_next;
        base_reg     <= base_next;
        col_addr_reg <= col_addr_next;
        dc_reg       <= dc_next;
        dr_reg       <= dr_next;
        rows_lim_reg <= rows_lim_next;
        scan_idx_reg <= scan_idx_next;
        fill_reg     <= fill_next;
        acc_reg      <= acc_next;
        line_reg     <= line_next;
        div_cnt_reg  <= div_cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_dark   = out_data_reg;
    assign m_last   = out_last_reg;

    `DCMF_ASSERT(a_window_in_frame, aclk, aresetn, (state_reg == ST_SETUP) |-> ((HB'(row_reg) < geo.h) && (WB'(col_reg) < geo.w)))
    `DCMF_ASSERT(a_scan_in_patch, aclk, aresetn, (state_reg == ST_SCAN) |-> (scan_idx_reg < geo.p))
    `DCMF_ASSERT(a_rows_in_patch, aclk, aresetn, (state_reg == ST_COL_READ) |-> ((dr_reg <= rows_lim_reg) && (rows_lim_reg <= geo.p)))
    `DCMF_ASSERT(a_frame_restart, aclk, aresetn, (out_load && pos_is_last) |=> ((n_reg == '0) && m_last))

endmodule

@@ sv/dark_channel_min_filter.sv @@
// ----------------------------------------------------------------------------
// dark_channel_min_filter: dark channel minimum over a forward patch.
// An item that yields no result is handled in the idle state. A result reads
// the whole window for the first of each row and only the new right column
// otherwise, through the single row-store read port and the one shared
// comparator; the first result after a register write also runs the
// position divider. Results lag by (P-1)*W+(P-1) items.
// Reset loads 640x480 with P=15, clears counters and holds input while the settle counter runs down.
`include "assert_macros.svh"

module dark_channel_min_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // red, green, blue
    input  logic                                s_tuser,   // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // dark_value
    output logic                                m_tlast,   // last_of_frame
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NB = dcmf_pkg::N_BITS;
    localparam int WB = dcmf_pkg::W_BITS;
    localparam int HB = dcmf_pkg::H_BITS;
    localparam int PS = dcmf_pkg::P_BITS;
    localparam logic [1:0] SETTLE = 2'd2;

    logic [dcmf_pkg::CFG_WIDTH_BITS-1:0]  width_reg;
    logic [dcmf_pkg::CFG_HEIGHT_BITS-1:0] height_reg;
    logic [dcmf_pkg::CFG_PATCH_BITS-1:0]  patch_reg;
    logic [1:0]                           settle_reg;
    logic                                 cfg_write;

    logic [WB-1:0]  w1_reg, w1_next;
    logic [HB-1:0]  h1_reg, h1_next;
    logic [PS-1:0]  p1_reg, p1_next;
    dcmf_pkg::geo_t geo_reg, geo_next;
    logic [NB-1:0]  pm1_ext, w_ext, h_ext;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= dcmf_pkg::WIDTH_RESET;
            height_reg <= dcmf_pkg::HEIGHT_RESET;
            patch_reg  <= dcmf_pkg::PATCH_RESET;
            settle_reg <= SETTLE;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    dcmf_pkg::REG_FRAME_WIDTH:
                        width_reg <= cfg_data[dcmf_pkg::CFG_WIDTH_BITS-1:0];
                    dcmf_pkg::REG_FRAME_HEIGHT:
                        height_reg <= cfg_data[dcmf_pkg::CFG_HEIGHT_BITS-1:0];
                    dcmf_pkg::REG_PATCH_SIZE:
                        patch_reg <= cfg_data[dcmf_pkg::CFG_PATCH_BITS-1:0];
                    default: begin
                    end
                endcase
                settle_reg <= SETTLE;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // Saturate the raw registers to their legal ranges.
    always_comb begin
        int wi;
        int hi;
        int pi;
        wi = int'(width_reg);
        hi = int'(height_reg);
        pi = int'(patch_reg);
        if (wi < 1) wi = 1;
        if (wi > dcmf_pkg::MAX_WIDTH) wi = dcmf_pkg::MAX_WIDTH;
        if (hi < 1) hi = 1;
        if (hi > dcmf_pkg::MAX_HEIGHT) hi = dcmf_pkg::MAX_HEIGHT;
        if (pi < 1) pi = 1;
        if (pi > dcmf_pkg::MAX_PATCH) pi = dcmf_pkg::MAX_PATCH;
        w1_next = WB'(wi);
        h1_next = HB'(hi);
        p1_next = PS'(pi);
    end

    assign pm1_ext = NB'(p1_reg - PS'(1));
    assign w_ext   = NB'(w1_reg);
    assign h_ext   = NB'(h1_reg);

    always_comb begin
        geo_next.w     = w1_reg;
        geo_next.h     = h1_reg;
        geo_next.p     = p1_reg;
        geo_next.lag   = pm1_ext * w_ext + pm1_ext;
        geo_next.total = w_ext * h_ext;
    end

    always_ff @(posedge aclk) begin
        w1_reg  <= w1_next;
        h1_reg  <= h1_next;
        p1_reg  <= p1_next;
        geo_reg <= geo_next;
    end

    dcmf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geo         (geo_reg),
        .geo_ready   (settle_reg == 2'd0),
        .geo_changed (cfg_write),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_op        (s_tuser),
        .s_red       (s_tdata[7:0]),
        .s_green     (s_tdata[15:8]),
        .s_blue      (s_tdata[23:16]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_dark      (m_tdata),
        .m_last      (m_tlast)
    );

    `DCMF_ASSERT(a_hold_while_settling, aclk, aresetn, (settle_reg != 2'd0) |-> !s_tready)
    `DCMF_ASSERT(a_write_settles, aclk, aresetn, cfg_write |=> (settle_reg == SETTLE))
    `DCMF_ASSERT(a_geo_in_range, aclk, aresetn, (settle_reg == 2'd0) |-> ((geo_reg.w != '0) && (geo_reg.p != '0) && (geo_reg.h != '0)))

endmodule

@@ test/tb_dark_channel_min_filter.sv @@
// ----------------------------------------------------------------------------
// tb_dark_channel_min_filter: self-checking bench for the dark channel filter.
// Sends pixel and drain requests with random gaps on both sides. A local
// line-store model predicts each clipped patch minimum as requests are
// accepted, and every result is checked in order against those predictions.
// ----------------------------------------------------------------------------
module tb_dark_channel_min_filter;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int BANK_DEPTH    = dcmf_pkg::MAX_PATCH * dcmf_pkg::MAX_WIDTH;
    localparam logic [dcmf_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [dcmf_pkg::PIX_BITS-1:0] dark;
        logic                          frame_end;
    } dark_result_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [23:0]                         s_tdata;   // red, green, blue
    logic                                s_tuser;   // operation
    logic                                m_tvalid;
    logic                                m_tready;
    logic [7:0]                          m_tdata;   // dark_value
    logic                                m_tlast;   // last_of_frame
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [dcmf_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [dcmf_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    // Predictor state: register copies, reduced pixel ring and frame position.
    logic [dcmf_pkg::CFG_WIDTH_BITS-1:0]  width_reg;
    logic [dcmf_pkg::CFG_HEIGHT_BITS-1:0] height_reg;
    logic [dcmf_pkg::CFG_PATCH_BITS-1:0]  patch_reg;
    logic [dcmf_pkg::PIX_BITS-1:0]        pixel_bank [0:BANK_DEPTH-1];
    int unsigned                          frame_pos;
    dark_result_t                         dark_q[$];

    int errors;
    int items_sent;
    int idle_cycles;
    int ready_hold;
    bit calm;

    dark_channel_min_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned clamp_geo(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void reset_model();
        width_reg  = dcmf_pkg::WIDTH_RESET;
        height_reg = dcmf_pkg::HEIGHT_RESET;
        patch_reg  = dcmf_pkg::PATCH_RESET;
        frame_pos  = 0;
        for (int i = 0; i < BANK_DEPTH; i++) pixel_bank[i] = '0;
    endfunction

    // Every request takes the next raster position; once the lag is covered it
    // yields the minimum over the clipped patch anchored at position n - lag.
    function automatic void predict_patch_min(logic op, logic [23:0] rgb);
        int unsigned w, h, p, total, lag, n, pos, r, c, dr, dc;
        logic [dcmf_pkg::PIX_BITS-1:0] v, best, px;
        w     = clamp_geo(32'(width_reg), dcmf_pkg::MAX_WIDTH);
        h     = clamp_geo(32'(height_reg), dcmf_pkg::MAX_HEIGHT);
        p     = clamp_geo(32'(patch_reg), dcmf_pkg::MAX_PATCH);
        total = w * h;
        lag   = (p - 1) * w + (p - 1);
        n     = frame_pos;
        v     = dcmf_pkg::PIX_MAX;
        if (op == dcmf_pkg::OP_PIXEL && n < total) begin
            v = rgb[7:0];
            if (rgb[15:8] < v) v = rgb[15:8];
            if (rgb[23:16] < v) v = rgb[23:16];
        end
        pixel_bank[n % BANK_DEPTH] = v;
        if (n < lag) begin
            frame_pos = n + 1;
            return;
        end
        pos = n - lag;
        // The geometry shrank under a running frame: drop it without a result.
        if (pos >= total) begin
            frame_pos = 0;
            return;
        end
        r    = pos / w;
        c    = pos % w;
        best = dcmf_pkg::PIX_MAX;
        for (dr = 0; dr < p; dr++) begin
            for (dc = 0; dc < p; dc++) begin
                if (r + dr < h && c + dc < w) begin
                    px = pixel_bank[((r + dr) * w + c + dc) % BANK_DEPTH];
                    if (px < best) best = px;
                end
            end
        end
        dark_q.push_back('{dark: best, frame_end: (pos == total - 1)});
        frame_pos = (pos == total - 1) ? 0 : n + 1;
    endfunction

    // Called at a falling edge; returns at a falling edge with tvalid still high.
    task automatic send_item(input logic op, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {blue, green, red};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_patch_min(op, {blue, green, red});
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input logic op);
        logic [23:0] rgb;
        rgb = 24'($urandom);
        send_item(op, rgb[7:0], rgb[15:8], rgb[23:16]);
    endtask

    task automatic write_reg(input logic [dcmf_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [dcmf_pkg::CFG_DATA_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dcmf_pkg::REG_FRAME_WIDTH:
                width_reg  = value[dcmf_pkg::CFG_WIDTH_BITS-1:0];
            dcmf_pkg::REG_FRAME_HEIGHT:
                height_reg = value[dcmf_pkg::CFG_HEIGHT_BITS-1:0];
            dcmf_pkg::REG_PATCH_SIZE:
                patch_reg  = value[dcmf_pkg::CFG_PATCH_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending, let every predicted result arrive, then give the block time
    // to finish any request that produces no result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (dark_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned p);
        write_reg(dcmf_pkg::REG_FRAME_WIDTH, dcmf_pkg::CFG_DATA_BITS'(w));
        write_reg(dcmf_pkg::REG_FRAME_HEIGHT, dcmf_pkg::CFG_DATA_BITS'(h));
        write_reg(dcmf_pkg::REG_PATCH_SIZE, dcmf_pkg::CFG_DATA_BITS'(p));
    endtask

    // A few requests under the reset geometry stay inside its long lag; the
    // shrink to 1x1 then abandons that frame before a fresh one-pixel frame.
    task automatic test_reset_geometry();
        send_item(dcmf_pkg::OP_PIXEL, 8'd10, 8'd20, 8'd30);
        send_item(dcmf_pkg::OP_PIXEL, 8'd0, 8'd0, 8'd0);
        send_item(dcmf_pkg::OP_DRAIN, 8'd255, 8'd255, 8'd255);
        wait_idle();
        set_geometry(1, 1, 1);
        send_item(dcmf_pkg::OP_PIXEL, 8'd5, 8'd6, 8'd7);
        send_item(dcmf_pkg::OP_PIXEL, 8'd99, 8'd42, 8'd77);
        wait_idle();
    endtask

    // Patch of one: each result is the channel minimum of its own pixel.
    task automatic test_channel_extremes();
        set_geometry(4, 2, 1);
        send_item(dcmf_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(dcmf_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(dcmf_pkg::OP_PIXEL, 8'h0F, 8'hF0, 8'hFF);
        send_item(dcmf_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hCC);
        send_item(dcmf_pkg::OP_PIXEL, 8'h81, 8'h80, 8'h7F);
        send_item(dcmf_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(dcmf_pkg::OP_PIXEL, 8'h01, 8'h01, 8'hFE);
        send_item(dcmf_pkg::OP_PIXEL, 8'hFE, 8'hFD, 8'hFF);
        wait_idle();
    endtask

    // 3x3 frame with a 2x2 patch: clipping at the right and bottom edges, and
    // both drains and late pixels flushing the tail.
    task automatic test_patch_clipping();
        set_geometry(3, 3, 2);
        for (int k = 0; k < 9; k++)
            send_item(dcmf_pkg::OP_PIXEL, 8'(k * 29 + 3), 8'(250 - k * 17),
                      8'(k * 53 + 40));
        send_item(dcmf_pkg::OP_DRAIN, 8'h12, 8'h34, 8'h56);
        send_item(dcmf_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(dcmf_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(dcmf_pkg::OP_PIXEL, 8'h01, 8'h02, 8'h03);
        wait_idle();
    endtask

    task automatic test_register_limits();
        // Width saturates to its maximum, patch zero saturates to one.
        set_geometry(8191, 1, 0);
        repeat (6) send_random(dcmf_pkg::OP_PIXEL);
        wait_idle();
        write_reg(dcmf_pkg::REG_FRAME_WIDTH, '0);
        send_random(dcmf_pkg::OP_PIXEL);
        wait_idle();
        // Tallest frame, one column wide.
        write_reg(dcmf_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        repeat (4) send_random(dcmf_pkg::OP_PIXEL);
        wait_idle();
        write_reg(dcmf_pkg::REG_FRAME_HEIGHT, '0);
        send_random(dcmf_pkg::OP_DRAIN);
        wait_idle();
        // Largest patch; the write to the unused index must change nothing.
        set_geometry(3, 2, 31);
        write_reg(REG_UNUSED, 13'h1FFF);
        repeat (6) send_random(dcmf_pkg::OP_PIXEL);
        for (int k = 0; k < 60; k++)
            send_random(k % 7 == 3 ? dcmf_pkg::OP_PIXEL : dcmf_pkg::OP_DRAIN);
        wait_idle();
    endtask

    // Mostly whole frames of random small geometry, some back to back, with
    // stray drains, late pixels and frames cut short or overrun.
    task automatic test_random_frames();
        int unsigned w, h, p, lag, npix, ntail, first;
        first = items_sent;
        while (items_sent < first + RANDOM_ITEMS) begin
            if (items_sent == first || $urandom_range(0, 3) != 0) begin
                wait_idle();
                w = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
                h = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 12);
                case ($urandom_range(0, 19))
                    0:       p = $urandom_range(9, 16);
                    1, 2, 3: p = $urandom_range(5, 8);
                    default: p = $urandom_range(1, 4);
                endcase
                set_geometry(w, h, p);
            end
            calm  = ($urandom_range(0, 4) == 0);
            lag   = (p - 1) * w + (p - 1);
            npix  = w * h;
            ntail = lag;
            if ($urandom_range(0, 6) == 0) ntail = $urandom_range(0, lag + 3);
            for (int k = 0; k < npix; k++)
                send_random($urandom_range(0, 19) == 0 ? dcmf_pkg::OP_DRAIN
                                                       : dcmf_pkg::OP_PIXEL);
            for (int k = 0; k < ntail; k++)
                send_random($urandom_range(0, 9) == 0 ? dcmf_pkg::OP_PIXEL
                                                      : dcmf_pkg::OP_DRAIN);
        end
        calm = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin : check_results
        dark_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (dark_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: expected none, actual %0d/%0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = dark_q.pop_front();
                if (m_tdata !== want.dark) begin
                    errors++;
                    $display("%0t: dark_value expected %0d actual %0d",
                             $time, want.dark, m_tdata);
                end
                if (m_tlast !== want.frame_end) begin
                    errors++;
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $time, want.frame_end, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = dcmf_pkg::OP_PIXEL;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = dcmf_pkg::REG_FRAME_WIDTH;
        cfg_data    = '0;
        errors      = 0;
        items_sent  = 0;
        idle_cycles = 0;
        ready_hold  = 0;
        calm        = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry();
        test_channel_extremes();
        test_patch_clipping();
        test_register_limits();
        test_random_frames();
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
